/* hdl/pmr_pkg.sv */
package pmr_pkg;

    // Pixel formats, by the code written to the color format register
    typedef enum logic [1:0] {
        FMT_RGB565   = 2'd0,
        FMT_RGB888   = 2'd1,
        FMT_XRGB8888 = 2'd2,
        FMT_GRAY     = 2'd3
    } fmt_t;

    // Configuration register indexes
    localparam logic [2:0] REG_COLOR_FORMAT = 3'd0;
    localparam logic [2:0] REG_LANDSCAPE    = 3'd1;
    localparam logic [2:0] REG_AREA_LEFT    = 3'd2;
    localparam logic [2:0] REG_AREA_TOP     = 3'd3;
    localparam logic [2:0] REG_AREA_WIDTH   = 3'd4;
    localparam logic [2:0] REG_AREA_HEIGHT  = 3'd5;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 9;

    localparam int PANEL_HEIGHT = 250;
    localparam logic [8:0] PANEL_LAST_ROW = 9'(PANEL_HEIGHT - 1);

    localparam logic [8:0] AREA_WIDTH_RST  = 9'd122;
    localparam logic [8:0] AREA_HEIGHT_RST = 9'd250;
    localparam logic [8:0] AREA_SIZE_MAX   = 9'd256;

    // Luma weights; brightness (sum / 100) >= 128 is the same as sum >= 12800
    localparam logic [4:0] LUMA_WR = 5'd30;
    localparam logic [5:0] LUMA_WG = 6'd59;
    localparam logic [3:0] LUMA_WB = 4'd11;
    localparam int LUMA_DIV   = 100;
    localparam int LUMA_LEVEL = 128;
    localparam logic [14:0] LUMA_THRESH_SUM = 15'(LUMA_LEVEL * LUMA_DIV);

    localparam int CH5_MAX = 31;
    localparam int CH6_MAX = 63;
    localparam int CH8_MAX = 255;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    typedef struct packed {
        logic [8:0] panel_x;
        logic [8:0] panel_y;
        logic       off_screen;
        logic       last_pixel;
    } coord_t;

    // Widen a 5-bit channel to 8 bits: c * 255 / 31, truncated
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [7:0] v;
        v = '0;
        for (int i = 0; i <= CH5_MAX; i++) begin
            if (c == 5'(i)) begin
                v = 8'((i * CH8_MAX) / CH5_MAX);
            end
        end
        return v;
    endfunction

    // Widen a 6-bit channel to 8 bits: c * 255 / 63, truncated
    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [7:0] v;
        v = '0;
        for (int i = 0; i <= CH6_MAX; i++) begin
            if (c == 6'(i)) begin
                v = 8'((i * CH8_MAX) / CH6_MAX);
            end
        end
        return v;
    endfunction

endpackage

/* hdl/pmr_mono.sv */
module pmr_mono
    import pmr_pkg::*;
(
    input  logic [31:0] pixel_word,
    input  fmt_t        color_format,
    output logic        mono_bit
);

    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [14:0] luma_sum;

    always_comb begin
        unique case (color_format)
            FMT_RGB565: begin
                r = expand5(pixel_word[15:11]);
                g = expand6(pixel_word[10:5]);
                b = expand5(pixel_word[4:0]);
            end
            FMT_RGB888: begin
                r = pixel_word[7:0];
                g = pixel_word[15:8];
                b = pixel_word[23:16];
            end
            FMT_XRGB8888: begin
                r = pixel_word[15:8];
                g = pixel_word[23:16];
                b = pixel_word[31:24];
            end
            FMT_GRAY: begin
                r = pixel_word[7:0];
                g = pixel_word[7:0];
                b = pixel_word[7:0];
            end
        endcase
    end

    assign luma_sum = 15'(r * LUMA_WR) + 15'(g * LUMA_WG) + 15'(b * LUMA_WB);
    assign mono_bit = (luma_sum >= LUMA_THRESH_SUM);

endmodule

/* hdl/pmr_coord.sv */
module pmr_coord
    import pmr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic       landscape,
    input  logic [7:0] area_left,
    input  logic [7:0] area_top,
    input  logic [8:0] area_width,
    input  logic [8:0] area_height,
    output coord_t     coord
);

    logic [7:0] column_count_reg;
    logic [7:0] column_count_next;
    logic [7:0] row_count_reg;
    logic [7:0] row_count_next;

    logic [8:0] width_eff;
    logic [8:0] height_eff;
    logic [7:0] last_col;
    logic [7:0] last_row;
    logic       col_end;
    logic       row_end;
    logic [8:0] col_sum;
    logic [8:0] row_sum;

    // Clamp sizes to 1..256
    always_comb begin
        priority if (area_width == '0) begin
            width_eff = 9'd1;
        end else if (area_width > AREA_SIZE_MAX) begin
            width_eff = AREA_SIZE_MAX;
        end else begin
            width_eff = area_width;
        end
        priority if (area_height == '0) begin
            height_eff = 9'd1;
        end else if (area_height > AREA_SIZE_MAX) begin
            height_eff = AREA_SIZE_MAX;
        end else begin
            height_eff = area_height;
        end
    end

    assign last_col = 8'(width_eff - 9'd1);
    assign last_row = 8'(height_eff - 9'd1);
    assign col_end  = (column_count_reg >= last_col);
    assign row_end  = (row_count_reg >= last_row);
    assign col_sum  = {1'b0, area_left} + {1'b0, column_count_reg};
    assign row_sum  = {1'b0, area_top} + {1'b0, row_count_reg};

    always_comb begin
        coord.last_pixel = col_end && row_end;
        if (landscape) begin
            coord.panel_x = row_sum;
            // rotated row goes negative once the column passes the last panel row
            if (col_sum > PANEL_LAST_ROW) begin
                coord.off_screen = 1'b1;
                coord.panel_y    = '0;
            end else begin
                coord.off_screen = 1'b0;
                coord.panel_y    = PANEL_LAST_ROW - col_sum;
            end
        end else begin
            coord.panel_x    = col_sum;
            coord.panel_y    = row_sum;
            coord.off_screen = 1'b0;
        end
    end

    always_comb begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (advance) begin
            if (col_end) begin
                column_count_next = '0;
                row_count_next    = row_end ? '0 : row_count_reg + 8'd1;
            end else begin
                column_count_next = column_count_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end else begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

endmodule

/* hdl/pixel_to_mono_rotate_top.sv */
// Pixel stream to monochrome panel pixels.
//
// Input: one 32-bit pixel word per transfer on s_axis, in raster order over
// the configured rectangle (columns first, then rows). Output: one transfer
// on m_axis per pixel with panel coordinates, the black/white bit, an
// off-screen flag in tuser and tlast on the final pixel of the rectangle.
// Configuration goes through cfg_we/cfg_addr/cfg_wdata and must be written
// while no pixels are in flight, not enforced; unused indexes are ignored.
//
// Throughput is one pixel per clock while m_axis_tready stays high. An input
// transfer reaches m_axis through an input stage, which holds the word and
// the coordinates taken from the column/row counters, and the output register,
// which the color decode and luma compare fill.
// A stall on m_axis_tready holds the output register; the input stage still
// takes a pixel if it is empty, after which s_axis_tready drops until the output
// drains. Reset empties both stages, zeroes the counters and loads the
// register defaults (rgb565, portrait, origin 0/0, 122 x 250).
module pixel_to_mono_rotate_top
    import pmr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [31:0] pixel_word

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata,  // [8:0] panel_x, [17:9] panel_y,
                                                 // [18] mono_bit, [23:19] zero
    output logic                  m_axis_tuser,  // [0] off_screen
    output logic                  m_axis_tlast   // last_pixel
);

    fmt_t       color_format_reg;
    logic       landscape_reg;
    logic [7:0] area_left_reg;
    logic [7:0] area_top_reg;
    logic [8:0] area_width_reg;
    logic [8:0] area_height_reg;

    logic        s1_valid_reg;
    logic [31:0] s1_word_reg;
    coord_t      s1_coord_reg;

    logic        m_valid_reg;
    coord_t      m_coord_reg;
    logic        m_mono_reg;

    logic   s_accept;
    logic   out_ready;
    logic   s1_advance;
    coord_t coord;
    logic   mono;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_format_reg <= FMT_RGB565;
            landscape_reg    <= 1'b0;
            area_left_reg    <= '0;
            area_top_reg     <= '0;
            area_width_reg   <= AREA_WIDTH_RST;
            area_height_reg  <= AREA_HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_COLOR_FORMAT: color_format_reg <= fmt_t'(cfg_wdata[1:0]);
                REG_LANDSCAPE:    landscape_reg    <= cfg_wdata[0];
                REG_AREA_LEFT:    area_left_reg    <= cfg_wdata[7:0];
                REG_AREA_TOP:     area_top_reg     <= cfg_wdata[7:0];
                REG_AREA_WIDTH:   area_width_reg   <= cfg_wdata;
                REG_AREA_HEIGHT:  area_height_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign s1_advance    = s1_valid_reg && out_ready;
    assign s_axis_tready = !s1_valid_reg || out_ready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    pmr_coord u_coord (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (s_accept),
        .landscape   (landscape_reg),
        .area_left   (area_left_reg),
        .area_top    (area_top_reg),
        .area_width  (area_width_reg),
        .area_height (area_height_reg),
        .coord       (coord)
    );

    pmr_mono u_mono (
        .pixel_word   (s1_word_reg),
        .color_format (color_format_reg),
        .mono_bit     (mono)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                s1_valid_reg <= s_axis_tvalid;
            end
            if (out_ready) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_word_reg  <= s_axis_tdata;
            s1_coord_reg <= coord;
        end
        if (s1_advance) begin
            m_coord_reg <= s1_coord_reg;
            m_mono_reg  <= mono;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, m_mono_reg, m_coord_reg.panel_y, m_coord_reg.panel_x};
    assign m_axis_tuser  = m_coord_reg.off_screen;
    assign m_axis_tlast  = m_coord_reg.last_pixel;

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !s1_valid_reg && !m_valid_reg)
        else $error("pipeline not empty after reset");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_axis_tready && s1_valid_reg |-> !s_axis_tready)
        else $error("input taken while both stages are full and stalled");

    a_stage_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && out_ready |=> m_valid_reg)
        else $error("pixel lost between input stage and output register");

    a_off_row_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_coord_reg.off_screen |-> m_coord_reg.panel_y == '0)
        else $error("off-screen pixel with nonzero row");

endmodule

/* tb/pixel_to_mono_rotate_checker.sv */
`timescale 1ns / 1ps

module pixel_to_mono_rotate_checker
    import pmr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // [31:0] pixel_word

    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [M_TDATA_W-1:0]  m_axis_tdata,  // [8:0] panel_x, [17:9] panel_y,
                                                 // [18] mono_bit, [23:19] zero
    input  logic                  m_axis_tuser,  // [0] off_screen
    input  logic                  m_axis_tlast,  // last_pixel

    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [8:0] x;
        logic [8:0] y;
        logic       mono;
        logic       off;
        logic       last;
    } panel_pixel_t;

    fmt_t       fmt;
    logic       rot;
    logic [7:0] left;
    logic [7:0] top;
    logic [8:0] width;
    logic [8:0] height;
    logic [7:0] col;
    logic [7:0] row;

    panel_pixel_t pixels_due[$];
    int           n_taken;
    int           n_given;
    int           shown;

    assign pending = n_taken - n_given;

    function automatic int widen_chan(input int c, input int cmax);
        return (c * CH8_MAX) / cmax;
    endfunction

    function automatic logic is_white(input logic [31:0] w, input fmt_t f);
        int r, g, b;
        case (f)
            FMT_RGB565: begin
                r = widen_chan(int'(w[15:11]), CH5_MAX);
                g = widen_chan(int'(w[10:5]), CH6_MAX);
                b = widen_chan(int'(w[4:0]), CH5_MAX);
            end
            FMT_RGB888: begin
                r = int'(w[7:0]);
                g = int'(w[15:8]);
                b = int'(w[23:16]);
            end
            FMT_XRGB8888: begin
                r = int'(w[15:8]);
                g = int'(w[23:16]);
                b = int'(w[31:24]);
            end
            default: begin
                r = int'(w[7:0]);
                g = r;
                b = r;
            end
        endcase
        return ((r * 30 + g * 59 + b * 11) / 100) >= 128;
    endfunction

    // zero acts as one, anything past 256 as 256
    function automatic int area_span(input logic [8:0] v);
        if (v == 9'd0)
            return 1;
        if (v > AREA_SIZE_MAX)
            return int'(AREA_SIZE_MAX);
        return int'(v);
    endfunction

    // Locate one pixel on the panel and advance the raster counters
    function automatic panel_pixel_t raster_step(input logic [31:0] w);
        panel_pixel_t res;
        int           yy;
        logic         col_end;
        logic         row_end;
        col_end = int'(col) >= area_span(width) - 1;
        row_end = int'(row) >= area_span(height) - 1;
        res.mono = is_white(w, fmt);
        res.last = col_end && row_end;
        res.off  = 1'b0;
        if (rot) begin
            yy    = (PANEL_HEIGHT - 1) - (int'(left) + int'(col));
            res.x = 9'(int'(top) + int'(row));
            if (yy < 0) begin
                res.off = 1'b1;
                res.y   = 9'd0;
            end else begin
                res.y = 9'(yy);
            end
        end else begin
            res.x = 9'(int'(left) + int'(col));
            res.y = 9'(int'(top) + int'(row));
        end
        if (col_end) begin
            col = 8'd0;
            row = row_end ? 8'd0 : row + 8'd1;
        end else begin
            col = col + 8'd1;
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        panel_pixel_t exp_px;
        panel_pixel_t got_px;
        if (!aresetn) begin
            fmt    = FMT_RGB565;
            rot    = 1'b0;
            left   = 8'd0;
            top    = 8'd0;
            width  = AREA_WIDTH_RST;
            height = AREA_HEIGHT_RST;
            col    = 8'd0;
            row    = 8'd0;
            shown  = 0;
            pixels_due.delete();
            n_taken <= 0;
            n_given <= 0;
            errors  <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_COLOR_FORMAT: fmt    = fmt_t'(cfg_wdata[1:0]);
                    REG_LANDSCAPE:    rot    = cfg_wdata[0];
                    REG_AREA_LEFT:    left   = cfg_wdata[7:0];
                    REG_AREA_TOP:     top    = cfg_wdata[7:0];
                    REG_AREA_WIDTH:   width  = cfg_wdata[8:0];
                    REG_AREA_HEIGHT:  height = cfg_wdata[8:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pixels_due.push_back(raster_step(s_axis_tdata));
                n_taken <= n_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got_px.x    = m_axis_tdata[8:0];
                got_px.y    = m_axis_tdata[17:9];
                got_px.mono = m_axis_tdata[18];
                got_px.off  = m_axis_tuser;
                got_px.last = m_axis_tlast;
                n_given <= n_given + 1;
                if (pixels_due.size() == 0) begin
                    errors <= errors + 1;
                    if (shown < 10)
                        $display("%0t: result with nothing pending: x=%0d y=%0d", $time,
                                 got_px.x, got_px.y);
                    shown++;
                end else begin
                    exp_px = pixels_due.pop_front();
                    if (got_px !== exp_px) begin
                        errors <= errors + 1;
                        if (shown < 10) begin
                            $display("%0t: mismatch, expected x=%0d y=%0d mono=%0b off=%0b last=%0b",
                                     $time, exp_px.x, exp_px.y, exp_px.mono, exp_px.off,
                                     exp_px.last);
                            $display("%0t:           got x=%0d y=%0d mono=%0b off=%0b last=%0b",
                                     $time, got_px.x, got_px.y, got_px.mono, got_px.off,
                                     got_px.last);
                        end
                        shown++;
                    end
                end
            end
        end
    end

endmodule

/* tb/tb_pixel_to_mono_rotate_top.sv */
`timescale 1ns / 1ps

module tb_pixel_to_mono_rotate_top;
    import pmr_pkg::*;

    localparam int RANDOM_ITEMS    = 130;
    localparam int ROW_SWEEP_ITEMS = 40;
    localparam int SWEEP_ITEMS     = 258;
    localparam int CYCLE_LIMIT     = 300000;
    localparam logic [2:0] REG_SPARE = 3'(REG_AREA_HEIGHT + 1);

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    int mismatches;
    int in_flight;
    bit src_burst  = 1'b0;
    bit sink_burst = 1'b0;

    always #5 aclk = ~aclk;

    pixel_to_mono_rotate_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    pixel_to_mono_rotate_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (mismatches),
        .pending       (in_flight)
    );

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_pixel(input logic [31:0] word);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // drop valid and hold until every pixel has come back
    task automatic end_phase();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (in_flight != 0);
    endtask

    task automatic run_phase(input int n);
        src_burst  = ($urandom_range(0, 3) == 0);
        sink_burst = ($urandom_range(0, 3) == 0);
        repeat (n) send_pixel($urandom);
        end_phase();
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_origin();
        case ($urandom_range(0, 4))
            0:       return 9'h000;
            1:       return 9'h1FF;
            default: return 9'($urandom);
        endcase
    endfunction

    // mostly small rectangles, with the clamped sizes now and then
    function automatic logic [CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return AREA_SIZE_MAX;
            2:       return 9'($urandom_range(257, 511));
            3:       return 9'd1;
            default: return 9'($urandom_range(1, 8));
        endcase
    endfunction

    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = sink_burst ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        fmt_t        f;
        logic [31:0] words[$];
        int          random_sent;
        int          n;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // each format at its extremes and around the threshold
        f = f.first();
        do begin
            write_reg(REG_COLOR_FORMAT, 9'(f));
            case (f)
                FMT_RGB565:   words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_0000,
                                        32'h0000_07E0, 32'h0000_F800};
                FMT_RGB888:   words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFF00_0000,
                                        32'h0080_8080, 32'h007F_7F7F};
                FMT_XRGB8888: words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_00FF,
                                        32'h8080_8000, 32'h7F7F_7F00};
                default:      words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FF00,
                                        32'h0000_0080, 32'h0000_007F};
            endcase
            foreach (words[k])
                send_pixel(words[k]);
            end_phase();
            f = f.next();
        end while (f != f.first());

        // landscape at the far corner: rotated row goes negative
        write_reg(REG_LANDSCAPE, 9'd1);
        write_reg(REG_AREA_LEFT, 9'h0FF);
        write_reg(REG_AREA_TOP, 9'h0FF);
        write_reg(REG_AREA_WIDTH, 9'd2);
        write_reg(REG_AREA_HEIGHT, 9'd2);
        repeat (4) send_pixel($urandom);
        end_phase();

        // row counter with zero width and oversize height
        write_reg(REG_COLOR_FORMAT, 9'($urandom));
        write_reg(REG_LANDSCAPE, 9'd0);
        write_reg(REG_AREA_LEFT, 9'($urandom));
        write_reg(REG_AREA_TOP, 9'h0FF);
        write_reg(REG_AREA_WIDTH, 9'd0);
        write_reg(REG_AREA_HEIGHT, 9'h1FF);
        run_phase(ROW_SWEEP_ITEMS);

        // column counter through its full range in landscape
        write_reg(REG_COLOR_FORMAT, 9'($urandom));
        write_reg(REG_LANDSCAPE, 9'd1);
        write_reg(REG_AREA_LEFT, 9'd0);
        write_reg(REG_AREA_TOP, 9'($urandom));
        write_reg(REG_AREA_WIDTH, AREA_SIZE_MAX);
        write_reg(REG_AREA_HEIGHT, 9'd1);
        run_phase(SWEEP_ITEMS);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            write_reg(REG_COLOR_FORMAT, 9'($urandom));
            write_reg(REG_LANDSCAPE, 9'($urandom));
            write_reg(REG_AREA_LEFT, pick_origin());
            write_reg(REG_AREA_TOP, pick_origin());
            write_reg(REG_AREA_WIDTH, pick_size());
            write_reg(REG_AREA_HEIGHT, pick_size());
            if ($urandom_range(0, 3) == 0)
                write_reg(3'(REG_SPARE + $urandom_range(0, 1)), 9'($urandom));
            n = $urandom_range(1, 40);
            run_phase(n);
            random_sent += n;
        end

        repeat (8) @(posedge aclk);
        if (mismatches == 0 && in_flight == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
